// ----- design/cbm_pkg.sv -----
// Package for the cartridge bank mapper: transaction payload types, access codes,
// target and mirroring codes, and reset constants. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  localparam int NAMETABLE_RAM_BYTES_DEF = 4096;

  localparam int PRG_BANKS_RST = 32;
  localparam int CHR_BANKS_RST = 256;

  typedef enum logic [2:0] {
    KIND_CPU_RD = 3'd0,
    KIND_CPU_WR = 3'd1,
    KIND_PPU_RD = 3'd2,
    KIND_PPU_WR = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_NT_RAM  = 3'd4
  } target_t;

  typedef enum logic [1:0] {
    MIR_HORIZONTAL  = 2'd0,
    MIR_VERTICAL    = 2'd1,
    MIR_FOUR_SCREEN = 2'd2
  } mirror_t;

  typedef enum logic [1:0] {
    CFG_PRG_ROM_BANKS = 2'd0,
    CFG_CHR_ROM_BANKS = 2'd1,
    CFG_FOUR_SCREEN   = 2'd2
  } cfg_index_t;

  // CPU register windows, address bits 14:13 above 0x8000
  typedef enum logic [1:0] {
    REG_BANK       = 2'd0,
    REG_MIRROR     = 2'd1,
    REG_IRQ_LATCH  = 2'd2,
    REG_IRQ_ENABLE = 2'd3
  } reg_region_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mapped_address;
    logic        write_enable;
    logic [7:0]  write_data;
    logic        irq_pulse;
    logic [1:0]  mirroring;
    logic        mirroring_changed;
  } rsp_t;

  typedef struct packed {
    logic [1:0] index;
    logic [8:0] data;
  } cfg_t;

  // Bank maps after reset, built from the reset sizes
  localparam logic [5:0] PRG_LAST_RST   = 6'(PRG_BANKS_RST - 1);
  localparam logic [5:0] PRG_SECOND_RST = 6'(PRG_BANKS_RST - 2);
  localparam logic [7:0] CHR_LAST_RST   = 8'(CHR_BANKS_RST - 1);
  localparam logic [7:0] CHR_SECOND_RST = 8'(CHR_BANKS_RST - 2);

endpackage

`default_nettype wire

// ----- design/cbm_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// Payload type is set by the instantiating level; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cbm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/cartridge_bank_mapper_scanline_irq_core.sv -----
// Cartridge bank mapper with scanline IRQ counter: address translation and registers.
// Depends on cbm_pkg and cbm_stream_if.
//
//   channel  dir  payload                      transaction when
//   cfg      in   index, data                  cfg.valid & cfg.ready (ready always high)
//   req      in   kind, address, data          req.valid & req.ready
//   rsp      out  target, address, we, irq...  rsp.valid & rsp.ready
//
// A request is decoded against the current bank and IRQ state and its response
// lands in the output register on the accepting edge.
// req.ready is high whenever the output register is empty or being drained, so a
// request can be taken every cycle. A stalled rsp holds and blocks only new requests.
// Synchronous reset restores the reset sizes, bank maps and IRQ state.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_scanline_irq_core
  import cbm_pkg::*;
#(
  parameter int NAMETABLE_RAM_BYTES = NAMETABLE_RAM_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  cbm_stream_if.sink   cfg,
  cbm_stream_if.sink   req,
  cbm_stream_if.source rsp
);

  localparam logic [11:0] NT_LIMIT = 12'(NAMETABLE_RAM_BYTES % 4096);
  localparam bit          NT_FULL  = (NAMETABLE_RAM_BYTES >= 4096);

  // configuration
  logic [6:0] prg_rom_banks;
  logic       four_screen;

  // mapper state
  logic [7:0] bank_values [8];
  logic [2:0] target_select;
  logic       prg_swap_mode;
  logic       chr_invert;
  logic [7:0] chr_bank_map [8];
  logic [5:0] prg_bank_map [4];
  logic [1:0] mirror_mode;
  logic       irq_enable;
  logic [7:0] irq_counter;
  logic [7:0] irq_latch;
  logic       reload_pending;

  // output register
  logic       out_valid;
  rsp_t       out_data;

  // next values
  logic [7:0] bank_values_next [8];
  logic [7:0] chr_bank_map_next [8];
  logic [5:0] prg_bank_map_next [4];
  logic [2:0] target_select_next;
  logic       prg_swap_mode_next;
  logic       chr_invert_next;
  logic [1:0] mirror_mode_next;
  logic       irq_enable_next;
  logic [7:0] irq_counter_next;
  logic [7:0] irq_latch_next;
  logic       reload_pending_next;
  logic       rebuild;
  rsp_t       rsp_next;

  logic       accept;
  req_t       r;
  logic       odd;
  logic [5:0] prg_bank;
  logic [7:0] chr_bank;
  logic [11:0] nt_off;
  logic [7:0] r0;
  logic [7:0] r1;
  logic [5:0] prg_last1;
  logic [5:0] prg_last2;

  assign cfg.ready   = 1'b1;
  assign req.ready   = !out_valid || rsp.ready;
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  assign r         = req.payload;
  assign odd       = r.address[0];
  assign prg_bank  = prg_bank_map[r.address[14:13]];
  assign chr_bank  = chr_bank_map[r.address[12:10]];
  assign prg_last1 = 6'(prg_rom_banks - 7'd1);
  assign prg_last2 = 6'(prg_rom_banks - 7'd2);

  always_comb begin
    nt_off = r.address[11:0];
    if (!NT_FULL && nt_off >= NT_LIMIT) begin
      nt_off = nt_off - NT_LIMIT;
    end
  end

  // request decode and state update
  always_comb begin
    bank_values_next    = bank_values;
    target_select_next  = target_select;
    prg_swap_mode_next  = prg_swap_mode;
    chr_invert_next     = chr_invert;
    mirror_mode_next    = mirror_mode;
    irq_enable_next     = irq_enable;
    irq_counter_next    = irq_counter;
    irq_latch_next      = irq_latch;
    reload_pending_next = reload_pending;
    rebuild             = 1'b0;
    rsp_next            = '0;

    case (r.kind)
      KIND_CPU_RD, KIND_CPU_WR: begin
        if (r.address[15:13] == 3'b011) begin
          rsp_next.target         = TGT_PRG_RAM;
          rsp_next.mapped_address = {6'd0, r.address[12:0]};
          if (r.kind == KIND_CPU_WR) begin
            rsp_next.write_enable = 1'b1;
            rsp_next.write_data   = r.data;
          end
        end else if (r.address[15]) begin
          if (r.kind == KIND_CPU_RD) begin
            rsp_next.target         = TGT_PRG_ROM;
            rsp_next.mapped_address = {prg_bank, r.address[12:0]};
          end else begin
            case (r.address[14:13])
              REG_BANK: begin
                if (!odd) begin
                  target_select_next = r.data[2:0];
                  prg_swap_mode_next = r.data[6];
                  chr_invert_next    = r.data[7];
                end else begin
                  bank_values_next[target_select] = r.data;
                  rebuild = 1'b1;
                end
              end
              REG_MIRROR: begin
                if (!odd) begin
                  mirror_mode_next = four_screen ? MIR_FOUR_SCREEN :
                                     (r.data[0] ? MIR_HORIZONTAL : MIR_VERTICAL);
                  rsp_next.mirroring_changed = 1'b1;
                end
              end
              REG_IRQ_LATCH: begin
                if (!odd) begin
                  irq_latch_next = r.data;
                end else begin
                  irq_counter_next    = '0;
                  reload_pending_next = 1'b1;
                end
              end
              REG_IRQ_ENABLE: begin
                irq_enable_next = odd;
              end
              default: begin
              end
            endcase
          end
        end
      end
      KIND_PPU_RD, KIND_PPU_WR: begin
        if (r.address[15:13] == 3'b000) begin
          if (r.kind == KIND_PPU_RD) begin
            rsp_next.target         = TGT_CHR_ROM;
            rsp_next.mapped_address = {1'b0, chr_bank, r.address[9:0]};
          end
        end else if (r.address[15:12] == 4'h2) begin
          rsp_next.target         = TGT_NT_RAM;
          rsp_next.mapped_address = {7'd0, nt_off};
          if (r.kind == KIND_PPU_WR) begin
            rsp_next.write_enable = 1'b1;
            rsp_next.write_data   = r.data;
          end
        end
      end
      KIND_TICK: begin
        if (irq_counter == '0 || reload_pending) begin
          irq_counter_next    = irq_latch;
          reload_pending_next = 1'b0;
        end else begin
          irq_counter_next   = irq_counter - 8'd1;
          rsp_next.irq_pulse = (irq_counter == 8'd1) && irq_enable;
        end
      end
      default: begin
      end
    endcase

    rsp_next.mirroring = mirror_mode_next;
  end

  // bank map rebuild from the updated bank values
  always_comb begin
    r0 = bank_values_next[0] & 8'hFE;
    r1 = bank_values_next[1] & 8'hFE;
    chr_bank_map_next = chr_bank_map;
    prg_bank_map_next = prg_bank_map;
    if (rebuild) begin
      if (chr_invert) begin
        chr_bank_map_next[4] = r0;
        chr_bank_map_next[5] = r0 + 8'd1;
        chr_bank_map_next[6] = r1;
        chr_bank_map_next[7] = r1 + 8'd1;
        chr_bank_map_next[0] = bank_values_next[2];
        chr_bank_map_next[1] = bank_values_next[3];
        chr_bank_map_next[2] = bank_values_next[4];
        chr_bank_map_next[3] = bank_values_next[5];
      end else begin
        chr_bank_map_next[0] = r0;
        chr_bank_map_next[1] = r0 + 8'd1;
        chr_bank_map_next[2] = r1;
        chr_bank_map_next[3] = r1 + 8'd1;
        chr_bank_map_next[4] = bank_values_next[2];
        chr_bank_map_next[5] = bank_values_next[3];
        chr_bank_map_next[6] = bank_values_next[4];
        chr_bank_map_next[7] = bank_values_next[5];
      end
      if (!prg_swap_mode) begin
        prg_bank_map_next[0] = bank_values_next[6][5:0];
        prg_bank_map_next[2] = prg_last2;
      end else begin
        prg_bank_map_next[0] = prg_last2;
        prg_bank_map_next[2] = bank_values_next[6][5:0];
      end
      prg_bank_map_next[1] = bank_values_next[7][5:0];
      prg_bank_map_next[3] = prg_last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_banks <= 7'(PRG_BANKS_RST);
      four_screen   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        CFG_PRG_ROM_BANKS: prg_rom_banks <= cfg.payload.data[6:0];
        CFG_FOUR_SCREEN:   four_screen   <= cfg.payload.data[0];
        // pattern size is ignored; the reset map always uses the reset size
        CFG_CHR_ROM_BANKS: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        bank_values[i]  <= '0;
        chr_bank_map[i] <= (i == 0 || i == 3) ? CHR_SECOND_RST : CHR_LAST_RST;
      end
      prg_bank_map[0] <= PRG_SECOND_RST;
      prg_bank_map[1] <= PRG_LAST_RST;
      prg_bank_map[2] <= PRG_SECOND_RST;
      prg_bank_map[3] <= PRG_LAST_RST;
      target_select   <= '0;
      prg_swap_mode   <= 1'b0;
      chr_invert      <= 1'b0;
      mirror_mode     <= MIR_HORIZONTAL;
      irq_enable      <= 1'b0;
      irq_counter     <= '0;
      irq_latch       <= '0;
      reload_pending  <= 1'b0;
    end else if (accept) begin
      bank_values    <= bank_values_next;
      chr_bank_map   <= chr_bank_map_next;
      prg_bank_map   <= prg_bank_map_next;
      target_select  <= target_select_next;
      prg_swap_mode  <= prg_swap_mode_next;
      chr_invert     <= chr_invert_next;
      mirror_mode    <= mirror_mode_next;
      irq_enable     <= irq_enable_next;
      irq_counter    <= irq_counter_next;
      irq_latch      <= irq_latch_next;
      reload_pending <= reload_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire
